// ----- rtl/core/spq_pkg.sv -----
// spq_pkg: shared sizes, codes and control types of the sorted priority queue
// no dependencies; used by the channel interfaces and every core module
`timescale 1ns / 1ps

package spq_pkg;

    // default configuration
    localparam int SPQ_DEPTH      = 8;
    localparam int SPQ_DATA_WIDTH = 32;
    localparam int SPQ_PRIO_WIDTH = 8;

    // fixed widths of the channel words
    localparam int IN_DATA_W  = 32;
    localparam int IN_PRIO_W  = 8;
    localparam int OUT_DATA_W = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_OUT_W = 4;

    // request opcodes
    localparam logic MODE_ENQUEUE = 1'b0;
    localparam logic MODE_DEQUEUE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } spq_status_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the request word
        logic execute;   // apply the latched request and load the response word
    } spq_cmd_t;

endpackage

// ----- rtl/core/spq_if.sv -----
// spq_if: valid/ready channel interfaces for request and response words
// depends on spq_pkg for the word field widths
`timescale 1ns / 1ps

interface spq_req_if;
    import spq_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic signed [IN_DATA_W-1:0] in_data;
    logic [IN_PRIO_W-1:0]        in_priority;

    modport source (output valid, output mode, output in_data, output in_priority,
                    input ready);
    modport sink   (input valid, input mode, input in_data, input in_priority,
                    output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [STATUS_W-1:0]          status;
    logic signed [OUT_DATA_W-1:0] out_data;
    logic [COUNT_OUT_W-1:0]       entry_count;

    modport source (output valid, output status, output out_data, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input out_data, input entry_count,
                    output ready);
endinterface

// ----- rtl/core/sorted_priority_queue_core.sv -----
// sorted_priority_queue_core: bounded priority queue, top level
// a request word is latched when taken; execute applies it and loads its response word
// one request at a time: a new word is taken only in the idle state of spq_ctrl
// the response register lets a new request be taken while a response still waits
// reset: asynchronous, active low; empties the queue, no response pending, entries undefined
// depends on spq_pkg, spq_if, spq_ctrl and spq_datapath
`timescale 1ns / 1ps

module sorted_priority_queue_core #(
    parameter int DEPTH      = spq_pkg::SPQ_DEPTH,
    parameter int DATA_WIDTH = spq_pkg::SPQ_DATA_WIDTH,
    parameter int PRIO_WIDTH = spq_pkg::SPQ_PRIO_WIDTH
) (
    input logic    clk,
    input logic    rst_n,
    spq_req_if.sink   request,
    spq_rsp_if.source response
);
    import spq_pkg::*;

    // command bundle from the sequencer to the datapath
    spq_cmd_t cmd;

    // sequencer: idle takes a request word, execute applies it once the
    // response register is free or being drained in the same cycle
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .rsp_valid (response.valid),
        .rsp_ready (response.ready),
        .cmd       (cmd)
    );

    // datapath: every held slot compares its priority against the new one
    // in parallel; an enqueue shifts the slots behind the insert point down
    // by one, a dequeue pops slot 0 and shifts all slots up by one
    spq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (request.mode),
        .in_data     (request.in_data),
        .in_priority (request.in_priority),
        .status      (response.status),
        .out_data    (response.out_data),
        .entry_count (response.entry_count)
    );

endmodule

// ----- rtl/core/spq_ctrl.sv -----
// spq_ctrl: request/response sequencing for the sorted priority queue
// depends on spq_pkg; drives commands into spq_datapath
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output spq_pkg::spq_cmd_t cmd
);
    import spq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    // response register can take a new word this cycle
    assign out_free = !rsp_valid_reg || rsp_ready;

    assign req_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign cmd.capture = req_valid && (state_reg == S_IDLE);
    assign cmd.execute = (state_reg == S_EXEC) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- rtl/core/spq_datapath.sv -----
// spq_datapath: sorted entry array with parallel compare-and-shift, response register
// depends on spq_pkg; commanded by spq_ctrl
`timescale 1ns / 1ps

module spq_datapath #(
    parameter int DEPTH      = spq_pkg::SPQ_DEPTH,
    parameter int DATA_WIDTH = spq_pkg::SPQ_DATA_WIDTH,
    parameter int PRIO_WIDTH = spq_pkg::SPQ_PRIO_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  spq_pkg::spq_cmd_t                    cmd,
    input  logic                                 mode,
    input  logic signed [spq_pkg::IN_DATA_W-1:0] in_data,
    input  logic [spq_pkg::IN_PRIO_W-1:0]        in_priority,
    output logic [spq_pkg::STATUS_W-1:0]         status,
    output logic signed [spq_pkg::OUT_DATA_W-1:0] out_data,
    output logic [spq_pkg::COUNT_OUT_W-1:0]      entry_count
);
    import spq_pkg::*;

    localparam int COUNT_W = $clog2(DEPTH + 1);

    // latched request word
    logic                  mode_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [PRIO_WIDTH-1:0] prio_reg;

    // entry array, slot 0 is served next
    logic [DATA_WIDTH-1:0] entry_data_reg [DEPTH];
    logic [DATA_WIDTH-1:0] entry_data_next [DEPTH];
    logic [PRIO_WIDTH-1:0] entry_prio_reg [DEPTH];
    logic [PRIO_WIDTH-1:0] entry_prio_next [DEPTH];
    logic [COUNT_W-1:0]    count_reg, count_next;

    // response word
    spq_status_t           status_reg, status_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [DATA_WIDTH+IN_DATA_W-1:0]   in_data_ext;
    logic [PRIO_WIDTH+IN_PRIO_W-1:0]   in_prio_ext;
    logic [DATA_WIDTH+OUT_DATA_W-1:0]  head_ext;
    logic [COUNT_W+COUNT_OUT_W-1:0]    count_ext;
    logic                  full, empty;
    logic [DEPTH-1:0]      place;   // slot sits at or behind the insert point

    assign in_data_ext = {{DATA_WIDTH{1'b0}}, in_data};
    assign in_prio_ext = {{PRIO_WIDTH{1'b0}}, in_priority};
    assign head_ext    = {{OUT_DATA_W{1'b0}}, entry_data_reg[0]};
    assign count_ext   = {{COUNT_OUT_W{1'b0}}, count_reg};

    assign full  = (count_reg == COUNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign status      = status_reg;
    assign out_data    = out_data_reg;
    assign entry_count = count_ext[COUNT_OUT_W-1:0];

    // unheld slots count as behind the insert point; held ones compare strictly
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            place[k] = (COUNT_W'(k) >= count_reg) || (entry_prio_reg[k] > prio_reg);
        end
    end

    always_comb
    begin
        entry_data_next = entry_data_reg;
        entry_prio_next = entry_prio_reg;
        count_next      = count_reg;
        status_next     = ST_OK;
        out_data_next   = '0;
        if (mode_reg == MODE_ENQUEUE)
        begin
            if (full)
            begin
                status_next = ST_OVERFLOW;
            end
            else
            begin
                count_next = count_reg + COUNT_W'(1);
                for (int k = 0; k < DEPTH; k++)
                begin
                    if (place[k])
                    begin
                        if (k == 0)
                        begin
                            entry_data_next[k] = data_reg;
                            entry_prio_next[k] = prio_reg;
                        end
                        else if (!place[k-1])
                        begin
                            entry_data_next[k] = data_reg;
                            entry_prio_next[k] = prio_reg;
                        end
                        else
                        begin
                            entry_data_next[k] = entry_data_reg[k-1];
                            entry_prio_next[k] = entry_prio_reg[k-1];
                        end
                    end
                end
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_UNDERFLOW;
            end
            else
            begin
                out_data_next = head_ext[OUT_DATA_W-1:0];
                count_next    = count_reg - COUNT_W'(1);
                for (int k = 0; k < DEPTH - 1; k++)
                begin
                    entry_data_next[k] = entry_data_reg[k+1];
                    entry_prio_next[k] = entry_prio_reg[k+1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            data_reg <= in_data_ext[DATA_WIDTH-1:0];
            prio_reg <= in_prio_ext[PRIO_WIDTH-1:0];
        end
        if (cmd.execute)
        begin
            entry_data_reg <= entry_data_next;
            entry_prio_reg <= entry_prio_next;
            status_reg     <= status_next;
            out_data_reg   <= out_data_next;
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for sorted_priority_queue_core
// depends on spq_pkg, spq_if and the core rtl; drives request words, checks response words
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int DEPTH      = SPQ_DEPTH;
    localparam int DATA_WIDTH = SPQ_DATA_WIDTH;
    localparam int PRIO_WIDTH = SPQ_PRIO_WIDTH;

    localparam int RANDOM_COMMANDS = 1830;
    localparam int MAX_WAIT        = 17;
    localparam int HOLD_AT_RESULT  = 600;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int TAIL_CYCLES     = 20;

    // one request word plus the sender's timing for it
    typedef struct {
        logic                        mode;
        logic signed [IN_DATA_W-1:0] data;
        logic [IN_PRIO_W-1:0]        prio;
        int                          gap;
        bit                          drain;   // wait until all responses are in first
    } queue_cmd_t;

    typedef struct {
        spq_status_t             status;
        logic [OUT_DATA_W-1:0]   data;
        logic [COUNT_OUT_W-1:0]  count;
    } queue_word_t;

    logic clk;
    logic rst_n;

    spq_req_if request_ch ();
    spq_rsp_if response_ch ();

    sorted_priority_queue_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // shadow copy of the queue contents, slot 0 served next
    logic [DATA_WIDTH-1:0] slot_data [DEPTH];
    logic [PRIO_WIDTH-1:0] slot_prio [DEPTH];
    int                    held_entries;

    queue_cmd_t  pending_cmds [$];
    queue_word_t expected_words [$];

    int fail_count   = 0;
    int results_seen = 0;
    bit req_fire     = 1'b0;
    bit rsp_fire     = 1'b0;

    // apply one request to the shadow queue and return its response word
    function automatic queue_word_t apply_command(queue_cmd_t c);
        queue_word_t           r;
        int                    pos;
        logic [PRIO_WIDTH-1:0] p;
        r.status = ST_OK;
        r.data   = '0;
        if (c.mode == MODE_ENQUEUE)
        begin
            if (held_entries >= DEPTH)
            begin
                r.status = ST_OVERFLOW;
            end
            else
            begin
                p   = c.prio[PRIO_WIDTH-1:0];
                pos = 0;
                // new entry goes behind every held entry of equal priority
                while (pos < held_entries && slot_prio[pos] <= p)
                    pos++;
                for (int k = held_entries; k > pos; k--)
                begin
                    slot_data[k] = slot_data[k-1];
                    slot_prio[k] = slot_prio[k-1];
                end
                slot_data[pos] = c.data[DATA_WIDTH-1:0];
                slot_prio[pos] = p;
                held_entries++;
            end
        end
        else
        begin
            if (held_entries == 0)
            begin
                r.status = ST_UNDERFLOW;
            end
            else
            begin
                r.data = OUT_DATA_W'(slot_data[0]);
                for (int k = 0; k + 1 < held_entries; k++)
                begin
                    slot_data[k] = slot_data[k+1];
                    slot_prio[k] = slot_prio[k+1];
                end
                held_entries--;
            end
        end
        r.count = COUNT_OUT_W'(held_entries);
        return r;
    endfunction

    // idle style: 0 never waits, 1 waits 0..MAX_WAIT, 2 mostly back to back
    function automatic int draw_wait(int style);
        if (style == 0)
            return 0;
        else if (style == 1)
            return $urandom_range(0, MAX_WAIT);
        else
            return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
    endfunction

    task automatic add_cmd(logic mode, logic signed [IN_DATA_W-1:0] data,
                           logic [IN_PRIO_W-1:0] prio, int gap, bit drain);
        queue_cmd_t c;
        c.mode  = mode;
        c.data  = data;
        c.prio  = prio;
        c.gap   = gap;
        c.drain = drain;
        pending_cmds.push_back(c);
    endtask

    // monitor: check the response word first, then predict the accepted request
    always @(posedge clk)
    begin
        queue_word_t want;
        queue_cmd_t  got;
        req_fire = rst_n && request_ch.valid && request_ch.ready;
        rsp_fire = rst_n && response_ch.valid && response_ch.ready;
        if (rsp_fire)
        begin
            results_seen++;
            if (expected_words.size() == 0)
            begin
                $error("response word with no request waiting for it");
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (response_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, response_ch.status);
                    fail_count++;
                end
                if (response_ch.out_data !== want.data)
                begin
                    $error("out_data: expected %h, got %h", want.data, response_ch.out_data);
                    fail_count++;
                end
                if (response_ch.entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count,
                           response_ch.entry_count);
                    fail_count++;
                end
            end
        end
        if (req_fire)
        begin
            got.mode  = request_ch.mode;
            got.data  = request_ch.in_data;
            got.prio  = request_ch.in_priority;
            got.gap   = 0;
            got.drain = 1'b0;
            expected_words.push_back(apply_command(got));
        end
    end

    // request driver: next word goes out after its gap, a drain word waits for an empty
    // expectation list
    int idle_left = 0;
    bit armed     = 1'b0;

    always @(negedge clk)
    begin
        queue_cmd_t c;
        bit         next_valid;
        if (rst_n && (req_fire || !request_ch.valid))
        begin
            next_valid = 1'b0;
            if (pending_cmds.size() > 0)
            begin
                if (!armed)
                begin
                    idle_left = pending_cmds[0].gap;
                    armed     = 1'b1;
                end
                if (idle_left > 0)
                begin
                    idle_left--;
                end
                else if (!(pending_cmds[0].drain && expected_words.size() != 0))
                begin
                    c = pending_cmds.pop_front();
                    request_ch.mode        <= c.mode;
                    request_ch.in_data     <= c.data;
                    request_ch.in_priority <= c.prio;
                    next_valid = 1'b1;
                    armed      = 1'b0;
                end
            end
            request_ch.valid <= next_valid;
        end
    end

    // response ready: a fresh wait per word, one long hold-off to back the block up
    int  rsp_idle  = 0;
    int  hold_left = 0;
    bit  held_once = 1'b0;

    always @(negedge clk)
    begin
        int w;
        if (rst_n)
        begin
            if (!held_once && results_seen >= HOLD_AT_RESULT)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                response_ch.ready <= 1'b0;
            end
            else if (rsp_fire)
            begin
                w = draw_wait((results_seen / 150) % 3);
                if (w > 0)
                begin
                    rsp_idle = w - 1;
                    response_ch.ready <= 1'b0;
                end
                else
                begin
                    response_ch.ready <= 1'b1;
                end
            end
            else if (rsp_idle > 0)
            begin
                rsp_idle--;
                response_ch.ready <= 1'b0;
            end
            else
            begin
                response_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((request_ch.valid && request_ch.ready) || (response_ch.valid && response_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int added;
        int seg_len;
        int enq_weight;
        int prio_style;
        int gap_style;
        int seg_index;
        logic [IN_PRIO_W-1:0] p;

        rst_n                  = 1'b0;
        request_ch.valid       = 1'b0;
        request_ch.mode        = MODE_ENQUEUE;
        request_ch.in_data     = '0;
        request_ch.in_priority = '0;
        response_ch.ready      = 1'b0;
        held_entries           = 0;

        // directed: underflow on empty, extremes, ties, fill, overflow, drain
        add_cmd(MODE_DEQUEUE, $urandom, IN_PRIO_W'($urandom), 0, 1'b0);
        add_cmd(MODE_ENQUEUE, 32'sd100, 8'd5, draw_wait(1), 1'b0);
        add_cmd(MODE_ENQUEUE, 32'h8000_0000, 8'd255, draw_wait(1), 1'b0);
        add_cmd(MODE_ENQUEUE, 32'h7fff_ffff, 8'd0, draw_wait(1), 1'b0);
        add_cmd(MODE_ENQUEUE, 32'sd0, 8'd5, draw_wait(1), 1'b0);
        add_cmd(MODE_ENQUEUE, -32'sd1, 8'd5, draw_wait(1), 1'b0);
        add_cmd(MODE_ENQUEUE, 32'sd7, 8'd128, 0, 1'b0);
        add_cmd(MODE_ENQUEUE, 32'h5555_5555, 8'd1, 0, 1'b0);
        add_cmd(MODE_ENQUEUE, 32'haaaa_aaaa, 8'd254, 0, 1'b0);
        // full queue, even the most urgent priority is refused
        add_cmd(MODE_ENQUEUE, 32'sd123, 8'd0, 0, 1'b0);
        for (int k = 0; k < DEPTH; k++)
            add_cmd(MODE_DEQUEUE, $urandom, IN_PRIO_W'($urandom), draw_wait(2), 1'b0);
        add_cmd(MODE_DEQUEUE, 32'hffff_ffff, 8'hff, 0, 1'b0);
        add_cmd(MODE_ENQUEUE, -32'sd1, 8'd255, 0, 1'b0);
        add_cmd(MODE_DEQUEUE, 32'sd0, 8'd0, 0, 1'b0);

        // random segments: enqueue bias walks the fill level between empty and full
        added     = 0;
        seg_index = 0;
        while (added < RANDOM_COMMANDS)
        begin
            seg_len    = $urandom_range(20, 80);
            prio_style = $urandom_range(0, 2);
            gap_style  = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
                0: enq_weight = 20;
                1: enq_weight = 50;
                2: enq_weight = 80;
                default: enq_weight = 95;
            endcase
            for (int k = 0; k < seg_len && added < RANDOM_COMMANDS; k++)
            begin
                if (prio_style == 0)
                    p = IN_PRIO_W'($urandom_range(0, 3));
                else if (prio_style == 1)
                    p = IN_PRIO_W'($urandom);
                else
                begin
                    case ($urandom_range(0, 3))
                        0: p = 8'd0;
                        1: p = 8'd1;
                        2: p = 8'd254;
                        default: p = 8'd255;
                    endcase
                end
                add_cmd(($urandom_range(0, 99) < enq_weight) ? MODE_ENQUEUE : MODE_DEQUEUE,
                        $urandom, p, draw_wait(gap_style),
                        (k == 0) && (seg_index % 10 == 0));
                added++;
            end
            seg_index++;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || request_ch.valid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
